/* design/sdeq_pkg.sv */
// Shared types and sizes for the sorted deadline event queue.
// No dependencies; imported by the cell, the top level and the bench.
`default_nettype none

package sdeq_pkg;

  localparam int NUM_EVENTS = 8;
  localparam int IdW        = 3;
  localparam int TimeW      = 32;
  localparam int DelayW     = 24;
  localparam int CountW     = $clog2(NUM_EVENTS + 1);
  localparam int QcountW    = 4;
  localparam int MaxOut     = 8;
  localparam int PopW       = $clog2(MaxOut);

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_POLL     = 1'b1
  } sdeq_op_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_POP    = 2'd3
  } sdeq_cmd_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] deadline;
  } sdeq_entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    sdeq_cmd_e   cmd;
    sdeq_entry_t key;
  } sdeq_ctrl_t;

endpackage

`default_nettype wire

/* design/sdeq_cell.sv */
// One slot of the deadline-ordered row: holds an id and its deadline.
// Depends on sdeq_pkg; instantiated by sorted_deadline_event_queue.
`default_nettype none

module sdeq_cell
  import sdeq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire sdeq_ctrl_t  ctrl_i,
  input  wire logic        occupied_i,
  input  wire logic        flag_i,
  input  wire sdeq_entry_t left_i,
  input  wire sdeq_entry_t right_i,
  output logic             flag_o,
  output sdeq_entry_t      entry_o
);

  sdeq_entry_t entry_q, entry_d;
  logic        match, le, hit;

  assign match = occupied_i && (entry_q.id == ctrl_i.key.id);
  assign le    = occupied_i && (entry_q.deadline <= ctrl_i.key.deadline);
  // remove: a hit here or further left; on insert the flag out says this slot stays in front
  assign hit   = flag_i | match;

  always_comb begin
    flag_o  = 1'b0;
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_REMOVE: begin
        flag_o = hit;
        if (hit) entry_d = right_i;
      end
      CMD_INSERT: begin
        flag_o = le;
        if (!le) begin
          if (flag_i) entry_d = ctrl_i.key;
          else        entry_d = left_i;
        end
      end
      CMD_POP: entry_d = right_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* design/sorted_deadline_event_queue.sv */
// Top level: command port, sequencer and the row of queue cells.
// Depends on sdeq_pkg and sdeq_cell.
//
// A word is taken when start_i is high and busy_o low. A schedule keeps busy_o high
// through ST_REMOVE (removing a queued copy of the id) and ST_INSERT (opening a gap
// at the sorted place); its acknowledge appears the cycle after. A poll keeps busy_o
// high until its due entries (at most 8) are popped or none is due, one result word a
// cycle, each registered; the row shifts one place per cycle. Results are strobed by
// res_valid_o for a single cycle and cannot be held off, so they must be taken as
// they appear. A new command may be issued while the final result is on the ports.
`default_nettype none

module sorted_deadline_event_queue
  import sdeq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               opcode_i,
  input  wire logic [IdW-1:0]     event_id_i,
  input  wire logic [TimeW-1:0]   current_time_i,
  input  wire logic [DelayW-1:0]  delay_i,
  output logic                    res_valid_o,
  output logic [IdW-1:0]          fired_id_o,
  output logic                    fired_o,
  output logic                    last_o,
  output logic [QcountW-1:0]      queued_count_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REMOVE = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_POLL   = 4'b1000
  } sdeq_state_e;

  sdeq_state_e       state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [PopW-1:0]   pops_q, pops_d;
  sdeq_entry_t       key_q, key_d;
  logic [TimeW-1:0]  now_q, now_d;

  logic              res_valid_q, res_valid_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic              res_fired_q, res_fired_d;
  logic              res_last_q, res_last_d;
  logic [CountW-1:0] res_count_q, res_count_d;

  sdeq_ctrl_t        ctrl;
  logic [NUM_EVENTS:0] flag;
  sdeq_entry_t       entry [NUM_EVENTS];
  logic [TimeW:0]    sum;
  logic              accept, full, head_due, next_due;

  assign accept = start_i && (state_q == ST_IDLE);
  assign sum    = {1'b0, current_time_i} + {{(TimeW + 1 - DelayW){1'b0}}, delay_i};
  assign full   = (count_q == CountW'(NUM_EVENTS));

  assign head_due = (count_q != '0) && (entry[0].deadline <= now_q);
  assign next_due = (count_q > CountW'(1)) && (entry[1].deadline <= now_q);

  always_comb begin
    ctrl.key = key_q;
    ctrl.cmd = CMD_HOLD;
    case (state_q)
      ST_REMOVE: ctrl.cmd = CMD_REMOVE;
      ST_INSERT: ctrl.cmd = full ? CMD_HOLD : CMD_INSERT;
      ST_POLL:   ctrl.cmd = head_due ? CMD_POP : CMD_HOLD;
      default:   ctrl.cmd = CMD_HOLD;
    endcase
  end

  assign flag[0] = (ctrl.cmd == CMD_INSERT);

  for (genvar i = 0; i < NUM_EVENTS; i++) begin : g_cell
    sdeq_entry_t left, right;
    if (i == 0) begin : g_first
      assign left = key_q;
    end else begin : g_mid
      assign left = entry[i-1];
    end
    if (i == NUM_EVENTS - 1) begin : g_tail
      assign right = entry[i];
    end else begin : g_body
      assign right = entry[i+1];
    end

    sdeq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (count_q > CountW'(i)),
      .flag_i     (flag[i]),
      .left_i     (left),
      .right_i    (right),
      .flag_o     (flag[i+1]),
      .entry_o    (entry[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pops_d      = pops_q;
    key_d       = key_q;
    now_d       = now_q;
    res_valid_d = 1'b0;
    res_id_d    = res_id_q;
    res_fired_d = res_fired_q;
    res_last_d  = res_last_q;
    res_count_d = res_count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d.id       = event_id_i;
          key_d.deadline = sum[TimeW] ? '1 : sum[TimeW-1:0];
          now_d          = current_time_i;
          pops_d         = '0;
          state_d        = (opcode_i == OP_POLL) ? ST_POLL : ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        // last flag out of the row says an old copy of the id was dropped
        if (flag[NUM_EVENTS]) count_d = count_q - CountW'(1);
        state_d = ST_INSERT;
      end
      ST_INSERT: begin
        if (!full) count_d = count_q + CountW'(1);
        res_valid_d = 1'b1;
        res_id_d    = key_q.id;
        res_fired_d = 1'b0;
        res_last_d  = 1'b1;
        res_count_d = full ? count_q : count_q + CountW'(1);
        state_d     = ST_IDLE;
      end
      ST_POLL: begin
        res_valid_d = 1'b1;
        if (head_due) begin
          count_d     = count_q - CountW'(1);
          pops_d      = pops_q + PopW'(1);
          res_id_d    = entry[0].id;
          res_fired_d = 1'b1;
          res_last_d  = !next_due || (pops_q == PopW'(MaxOut - 1));
          res_count_d = count_q - CountW'(1);
          if (res_last_d) state_d = ST_IDLE;
        end else begin
          // nothing due at the first step
          res_id_d    = '0;
          res_fired_d = 1'b0;
          res_last_d  = 1'b1;
          res_count_d = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pops_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pops_q      <= pops_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    now_q       <= now_d;
    res_id_q    <= res_id_d;
    res_fired_q <= res_fired_d;
    res_last_q  <= res_last_d;
    res_count_q <= res_count_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign res_valid_o    = res_valid_q;
  assign fired_id_o     = res_id_q;
  assign fired_o        = res_fired_q;
  assign last_o         = res_last_q;
  assign queued_count_o = QcountW'(res_count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(NUM_EVENTS))
    else $error("queue count beyond capacity");

  a_busy_ends_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o && last_o)
    else $error("command finished without a final result word");

  a_ack_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !fired_o |-> last_o)
    else $error("non-fired result word not marked last");

  a_result_from_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result word without a command in flight");

  a_pop_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POLL) && head_due |=> count_q == $past(count_q) - CountW'(1))
    else $error("pop did not shrink the queue");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for sorted_deadline_event_queue: schedules and polls against
// an internal deadline-ordered model. Depends on sdeq_pkg and the design top level.
// A driver and a result monitor run as clocked blocks; an initial block queues commands.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdeq_pkg::*;

  typedef struct {
    sdeq_op_e          op;
    logic [IdW-1:0]    id;
    logic [TimeW-1:0]  now;
    logic [DelayW-1:0] dly;
  } event_cmd_t;

  typedef struct {
    logic [IdW-1:0]     id;
    logic               fired;
    logic               last;
    logic [QcountW-1:0] count;
  } event_word_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               opcode_i       = OP_SCHEDULE;
  logic [IdW-1:0]     event_id_i     = '0;
  logic [TimeW-1:0]   current_time_i = '0;
  logic [DelayW-1:0]  delay_i        = '0;
  logic               busy_o;
  logic               res_valid_o;
  logic [IdW-1:0]     fired_id_o;
  logic               fired_o;
  logic               last_o;
  logic [QcountW-1:0] queued_count_o;

  sorted_deadline_event_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .event_id_i     (event_id_i),
    .current_time_i (current_time_i),
    .delay_i        (delay_i),
    .res_valid_o    (res_valid_o),
    .fired_id_o     (fired_id_o),
    .fired_o        (fired_o),
    .last_o         (last_o),
    .queued_count_o (queued_count_o)
  );

  always #5 clk_i = ~clk_i;

  event_cmd_t  pending_cmds[$];
  event_word_t expected_words[$];
  event_cmd_t  cur_cmd;

  int unsigned cmds_total   = 0;
  int unsigned cmds_sent    = 0;
  int unsigned words_seen   = 0;
  int unsigned events_fired = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_left    = 0;
  logic        burst_mode   = 1'b0;

  // model of the queue: ids and deadlines, earliest first
  logic [IdW-1:0]   model_ids       [NUM_EVENTS];
  logic [TimeW-1:0] model_deadlines [NUM_EVENTS];
  int               model_count = 0;

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < model_count; i++) begin
      model_ids[i]       = model_ids[i + 1];
      model_deadlines[i] = model_deadlines[i + 1];
    end
    if (model_count > 0) model_count--;
  endfunction

  function automatic void predict_event_words(input event_cmd_t c);
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] deadline;
    event_word_t      w;
    event_word_t      prev;
    int               pos;
    bit               have_prev;
    have_prev = 1'b0;
    if (c.op == OP_SCHEDULE) begin
      sum      = {1'b0, c.now} + {{(TimeW + 1 - DelayW){1'b0}}, c.dly};
      deadline = sum[TimeW] ? '1 : sum[TimeW-1:0];
      for (int i = 0; i < model_count; i++) begin
        if (model_ids[i] == c.id) begin
          drop_entry(i);
          break;
        end
      end
      if (model_count < NUM_EVENTS) begin
        pos = 0;
        while (pos < model_count && model_deadlines[pos] <= deadline) pos++;
        for (int i = model_count; i > pos; i--) begin
          model_ids[i]       = model_ids[i - 1];
          model_deadlines[i] = model_deadlines[i - 1];
        end
        model_ids[pos]       = c.id;
        model_deadlines[pos] = deadline;
        model_count++;
      end
      w = '{c.id, 1'b0, 1'b1, QcountW'(model_count)};
      expected_words = {expected_words, w};
    end else begin
      // hold each popped word back until we know whether it is the final one
      pos = 0;
      while (pos < MaxOut && model_count > 0 && model_deadlines[0] <= c.now) begin
        if (have_prev) expected_words = {expected_words, prev};
        prev.id = model_ids[0];
        drop_entry(0);
        prev.fired = 1'b1;
        prev.last  = 1'b0;
        prev.count = QcountW'(model_count);
        have_prev  = 1'b1;
        pos++;
      end
      if (have_prev) begin
        prev.last = 1'b1;
        expected_words = {expected_words, prev};
      end else begin
        w = '{'0, 1'b0, 1'b1, QcountW'(model_count)};
        expected_words = {expected_words, w};
      end
    end
  endfunction

  task automatic apply_cmd(input event_cmd_t c);
    opcode_i       <= c.op;
    event_id_i     <= c.id;
    current_time_i <= c.now;
    delay_i        <= c.dly;
    start_i        <= 1'b1;
  endtask

  task automatic add_cmd(input sdeq_op_e op, input logic [IdW-1:0] id,
                         input logic [TimeW-1:0] now, input logic [DelayW-1:0] dly);
    event_cmd_t c;
    c = '{op, id, now, dly};
    pending_cmds = {pending_cmds, c};
    cmds_total++;
  endtask

  // driver: a word is taken when start_i is high and busy_o low
  always @(posedge clk_i) begin : driver
    int unsigned gap;
    if (!rst_ni) begin
      start_i   <= 1'b0;
      idle_left <= 0;
    end else if (start_i && !busy_o) begin
      predict_event_words(cur_cmd);
      cmds_sent++;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 31) == 0) burst_mode <= !burst_mode;
      if (gap == 0 && pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        apply_cmd(cur_cmd);
      end else begin
        start_i   <= 1'b0;
        // the cycle that sees the count run out is itself one of the idle cycles
        idle_left <= (gap != 0) ? gap - 1 : 0;
      end
    end else if (!start_i) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
      end else if (pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        apply_cmd(cur_cmd);
      end
    end
  end

  // monitor: results cannot be held off, so every strobed word is checked
  always @(posedge clk_i) begin : monitor
    event_word_t w;
    if (rst_ni && res_valid_o) begin
      words_seen++;
      if (fired_o) events_fired++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word id=%0d fired=%0b last=%0b count=%0d", $time,
                 fired_id_o, fired_o, last_o, queued_count_o);
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        if (fired_id_o !== w.id) begin
          $display("%0t: fired_id expected %0d got %0d", $time, w.id, fired_id_o);
          mismatches++;
        end
        if (fired_o !== w.fired) begin
          $display("%0t: fired expected %0b got %0b", $time, w.fired, fired_o);
          mismatches++;
        end
        if (last_o !== w.last) begin
          $display("%0t: last expected %0b got %0b", $time, w.last, last_o);
          mismatches++;
        end
        if (queued_count_o !== w.count) begin
          $display("%0t: queued_count expected %0d got %0d", $time, w.count,
                   queued_count_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [TimeW-1:0]  tick;
    logic [DelayW-1:0] dly;
    int unsigned       sel;
    int unsigned       pick;

    // empty poll, zero delay, saturating deadlines and equal deadlines
    add_cmd(OP_POLL,     3'd0, 32'd0,          24'd0);
    add_cmd(OP_SCHEDULE, 3'd0, 32'd0,          24'd0);
    add_cmd(OP_SCHEDULE, 3'd7, 32'hFFFF_FFFF,  24'hFF_FFFF);
    add_cmd(OP_SCHEDULE, 3'd3, 32'hFFFF_FF00,  24'h00_1000);
    add_cmd(OP_SCHEDULE, 3'd1, 32'd100,        24'd50);
    add_cmd(OP_SCHEDULE, 3'd2, 32'd100,        24'd50);
    // reschedule of a queued id moves it
    add_cmd(OP_SCHEDULE, 3'd1, 32'd120,        24'd100);
    add_cmd(OP_POLL,     3'd5, 32'd149,        24'hFF_FFFF);
    add_cmd(OP_POLL,     3'd0, 32'd150,        24'd0);
    // fill every slot, then reschedule with the queue full
    add_cmd(OP_SCHEDULE, 3'd0, 32'd200,        24'd0);
    add_cmd(OP_SCHEDULE, 3'd2, 32'd200,        24'd6);
    add_cmd(OP_SCHEDULE, 3'd4, 32'd200,        24'd12);
    add_cmd(OP_SCHEDULE, 3'd5, 32'd200,        24'd6);
    add_cmd(OP_SCHEDULE, 3'd6, 32'd200,        24'd18);
    add_cmd(OP_SCHEDULE, 3'd4, 32'd205,        24'd1);
    // everything due at once: eight words from one poll
    add_cmd(OP_POLL,     3'd7, 32'hFFFF_FFFF,  24'h55_AAAA);
    add_cmd(OP_POLL,     3'd2, 32'd0,          24'hAA_5555);

    tick = 32'd1000;
    repeat (500) begin
      sel = $urandom_range(0, 99);
      if (sel < 3)      tick = 32'hFFFF_FF00 + $urandom_range(0, 255);
      else if (sel < 6) tick = $urandom;
      else              tick = tick + $urandom_range(0, 24);
      if (sel >= 6 && sel < 55) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      dly = DelayW'($urandom);
        else if (pick == 1) dly = '0;
        else if (pick == 2) dly = '1;
        else                dly = DelayW'($urandom_range(0, 60));
        add_cmd(OP_SCHEDULE, IdW'($urandom_range(0, 7)), tick, dly);
      end else if (sel < 92) begin
        add_cmd(OP_POLL, IdW'($urandom), tick, DelayW'($urandom));
      end else begin
        // noise: any field, any time
        add_cmd(sdeq_op_e'($urandom_range(0, 1)), IdW'($urandom), $urandom,
                DelayW'($urandom));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_sent != cmds_total || expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d schedule/poll commands; checked %0d result words, %0d of them fired.",
             cmds_sent, words_seen, events_fired);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
design/sdeq_pkg.sv
design/sdeq_cell.sv
design/sorted_deadline_event_queue.sv
tb/tb_top.sv
